### design/lap3_pkg.sv
// lap3_pkg: shared constants, transaction types and helpers of the 3x3 Laplacian filter.
// No dependencies; imported by every module of the block except lap3_ram.
package lap3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int VAL_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

  // Pixel tagged by the front end with its column and classification
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } result_t;

  // Last valid index of a dimension, register value clamped to [3, hi]
  function automatic logic [COL_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] d;
    begin
      if (v < DIM_W'(3)) begin
        d = DIM_W'(3);
      end else if (v > hi) begin
        d = hi;
      end else begin
        d = v;
      end
      d = d - DIM_W'(1);
      return d[COL_W-1:0];
    end
  endfunction

endpackage

### design/laplacian_3x3_filter.sv
// laplacian_3x3_filter: top level of the four-neighbour 3x3 Laplacian filter.
// Depends on lap3_pkg, lap3_front, lap3_queue, lap3_back (and lap3_ram below it).
//
//   channel   ports                            transaction when
//   --------  -------------------------------  ------------------------------
//   pixels    push, full, pixel                push && !full
//   results   empty, pop, edge_value,          pop && !empty
//             frame_last
//   config    cfg_we, cfg_index, cfg_data      cfg_we
//
// One pixel per cycle sustained while full stays low. The front end is
// combinational; a pixel is written into the tag queue at the edge that takes
// it, then passes stage B, the line store read (registered RAM port). Its
// result is then written into the result queue and can be popped from there.
// Reset is synchronous; it empties both queues, restarts the frame and loads
// 640 x 480. Line stores are not cleared: rows 0 and 1 of each frame refill
// every entry before a result needs it.
// A stalled result side fills the 4-entry result queue, then the 2-entry tag
// queue, and only then raises full.
module laplacian_3x3_filter (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                push,
  output logic                                full,
  input  logic [lap3_pkg::PIX_W-1:0]          pixel,
  // results
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lap3_pkg::VAL_W-1:0]   edge_value,
  output logic                                frame_last,
  // configuration
  input  logic                                cfg_we,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lap3_pkg::DIM_W-1:0]          cfg_data
);
  import lap3_pkg::*;

  logic q_push;
  tag_t q_wdata;
  logic q_full;
  logic q_valid;
  logic q_pop;
  tag_t q_rdata;

  assign full = q_full;

  // front end: counters, clamped dimensions, emit and last flags
  lap3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .pixel     (pixel),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // decouples the front end from back end stalls
  lap3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // back end: line stores, window, kernel, result queue
  lap3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .edge_value (edge_value),
    .frame_last (frame_last)
  );

endmodule

### design/lap3_ram.sv
// lap3_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module lap3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/lap3_front.sv
// lap3_front: configuration registers, raster counters and classification of input pixels.
// Depends on lap3_pkg.
module lap3_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lap3_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            push,
  input  logic [lap3_pkg::PIX_W-1:0]      pixel,
  input  logic                            q_full,
  output logic                            q_push,
  output lap3_pkg::tag_t                  q_data
);
  import lap3_pkg::*;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  assign col_last = last_index(frame_width, DIM_W'(MAX_WIDTH));
  assign row_last = ROW_W'(last_index(frame_height, DIM_W'(MAX_HEIGHT)));

  assign q_push       = push && !q_full;
  assign q_data.pixel = pixel;
  assign q_data.col   = col;
  assign q_data.emit  = (row >= ROW_W'(2)) && (col >= COL_W'(2));
  assign q_data.last  = q_data.emit && (row == row_last) && (col == col_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      // any write restarts the frame
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else begin
        frame_height <= cfg_data;
      end
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

### design/lap3_queue.sv
// lap3_queue: two-entry queue of tagged pixels between front and back end.
// Depends on lap3_pkg.
module lap3_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  lap3_pkg::tag_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           valid,
  output lap3_pkg::tag_t rdata
);
  import lap3_pkg::*;

  tag_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### design/lap3_back.sv
// lap3_back: line stores, 3x3 window, kernel sum and the result queue.
// Depends on lap3_pkg and lap3_ram.
module lap3_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  lap3_pkg::tag_t                      q_data,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lap3_pkg::VAL_W-1:0]   edge_value,
  output logic                                frame_last
);
  import lap3_pkg::*;

  // stage B: pixel whose line store read is in flight
  logic             b_valid;
  tag_t             b_tag;
  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;

  // window columns that still matter: north/south at c-1, middle row at c-2 and c-1
  logic [PIX_W-1:0] top_prev;
  logic [PIX_W-1:0] mid_prev;
  logic [PIX_W-1:0] mid_prev2;
  logic [PIX_W-1:0] bot_prev;

  logic signed [VAL_W:0] sum;

  result_t            out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_PTR_W:0]   count;
  logic                 out_wr;
  logic                 out_rd;

  // issue only when the result queue has a slot for everything in flight
  assign q_pop = q_valid && ((count + {{OUT_PTR_W{1'b0}}, b_valid}) < (OUT_PTR_W+1)'(OUT_DEPTH));

  lap3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_tag.col),
    .wdata (mid_rd),
    .raddr (q_data.col),
    .rdata (top_rd)
  );

  lap3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_tag.col),
    .wdata (b_tag.pixel),
    .raddr (q_data.col),
    .rdata (mid_rd)
  );

  // 4*centre - north - south - west - east
  always_comb begin
    sum = $signed({2'b00, mid_prev, 2'b00})
        - $signed({4'b0000, top_prev})
        - $signed({4'b0000, bot_prev})
        - $signed({4'b0000, mid_prev2})
        - $signed({4'b0000, mid_rd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_tag <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_prev  <= '0;
      mid_prev  <= '0;
      mid_prev2 <= '0;
      bot_prev  <= '0;
    end else if (b_valid) begin
      top_prev  <= top_rd;
      mid_prev2 <= mid_prev;
      mid_prev  <= mid_rd;
      bot_prev  <= b_tag.pixel;
    end
  end

  // result queue
  assign out_wr     = b_valid && b_tag.emit;
  assign out_rd     = pop && !empty;
  assign empty      = (count == '0);
  assign edge_value = out_q[rd_ptr].value;
  assign frame_last = out_q[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_q[wr_ptr].value <= sum[VAL_W-1:0];
      out_q[wr_ptr].last  <= b_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (out_wr) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (out_rd) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + {{OUT_PTR_W{1'b0}}, out_wr} - {{OUT_PTR_W{1'b0}}, out_rd};
    end
  end

endmodule

### design/lap3_checker.sv
// lap3_checker: port-level assertions for laplacian_3x3_filter, attached by bind.
// Depends on lap3_pkg.
module lap3_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [lap3_pkg::VAL_W-1:0]   edge_value,
  input logic                                frame_last
);
  import lap3_pkg::*;

  // reset leaves no result waiting and room for input
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  // kernel response stays within 4*255
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (edge_value <= VAL_W'(1020)) && (edge_value >= -VAL_W'(1020)))
    else $error("edge_value out of range");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(edge_value) && $stable(frame_last)))
    else $error("waiting result changed");

endmodule

bind laplacian_3x3_filter lap3_checker u_checker (.*);
